FILE: rtl/core/krd_pkg.sv
package krd_pkg;

  // Default key count
  localparam int NUM_KEYS_DEF = 72;

  // Field widths
  localparam int KEY_W  = 7;
  localparam int NOTE_W = 8;
  localparam int CNT_W  = 8;
  localparam int VEL_W  = 7;
  localparam int STAT_W = 8;

  // Wide enough to compare a key index against any supported key count
  localparam int KEY_CMP_W = 9;

  // Front-to-back command queue
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);

  // MIDI codes
  localparam logic [STAT_W-1:0] STATUS_ON     = 8'h90;
  localparam logic [STAT_W-1:0] STATUS_OFF    = 8'h80;
  localparam logic [NOTE_W-1:0] NOTE_UNMAPPED = 8'hFF;

  // Register reset values
  localparam logic [CNT_W-1:0]  TIMEOUT_RST  = 8'd25;
  localparam logic [NOTE_W-1:0] OFFSET_RST   = 8'd47;
  localparam logic [VEL_W-1:0]  VELOCITY_RST = 7'd127;

  // Register map (word index)
  localparam int          PADDR_W      = 4;
  localparam logic [1:0]  REG_TIMEOUT  = 2'd0;
  localparam logic [1:0]  REG_OFFSET   = 2'd1;
  localparam logic [1:0]  REG_VELOCITY = 2'd2;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_MAP    = 1'b1
  } krd_op_t;

  typedef enum logic {
    BK_IDLE,
    BK_EXEC
  } krd_bk_state_t;

  typedef struct packed {
    krd_op_t           op;
    logic [KEY_W-1:0]  key;
    logic              level;
    logic [NOTE_W-1:0] note;
  } krd_cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0]  timeout;
    logic [NOTE_W-1:0] offset;
    logic [VEL_W-1:0]  velocity;
  } krd_cfg_t;

endpackage

FILE: rtl/core/krd_front.sv
module krd_front
  import krd_pkg::*;
#(
  parameter int NUM_KEYS = NUM_KEYS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  logic              operation,
  input  logic [KEY_W-1:0]  key_index,
  input  logic              pin_level,
  input  logic [NOTE_W-1:0] map_note,
  output logic              cmd_valid,
  output krd_cmd_t          cmd,
  input  logic              cmd_pop
);

  krd_cmd_t            q_mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]     cnt_r, cnt_nxt;
  logic                in_range;
  logic                accept;
  logic                wr_en;
  logic                rd_en;

  // keys past the end are taken and dropped
  assign in_range = (KEY_CMP_W'(key_index) < KEY_CMP_W'(NUM_KEYS));
  assign accept   = push && !full;
  assign wr_en    = accept && in_range;
  assign rd_en    = cmd_pop && cmd_valid;

  assign full      = (cnt_r == (QPTR_W+1)'(QDEPTH));
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (wr_en) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (rd_en && !wr_en) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      q_mem_r[wr_ptr_r] <= '{op:    krd_op_t'(operation),
                             key:   key_index,
                             level: pin_level,
                             note:  map_note};
    end
  end

endmodule

FILE: rtl/core/krd_back.sv
module krd_back
  import krd_pkg::*;
#(
  parameter int NUM_KEYS = NUM_KEYS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  krd_cfg_t          cfg,
  input  logic              cmd_valid,
  input  krd_cmd_t          cmd,
  output logic              cmd_pop,
  output logic              empty,
  input  logic              pop,
  output logic [STAT_W-1:0] status_byte,
  output logic [NOTE_W-1:0] note_number,
  output logic [VEL_W-1:0]  velocity
);

  localparam int ADDR_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

  krd_bk_state_t       state_r, state_nxt;

  logic [CNT_W-1:0]    cnt_mem [NUM_KEYS];
  logic [NOTE_W-1:0]   map_mem [NUM_KEYS];
  logic [NUM_KEYS-1:0] cnt_vld_r;
  logic [NUM_KEYS-1:0] map_vld_r;

  logic [ADDR_W-1:0]   cmd_addr;
  logic [ADDR_W-1:0]   addr_r;
  logic                lvl_r;
  logic [CNT_W-1:0]    rd_cnt_r;
  logic                rd_cnt_vld_r;
  logic [NOTE_W-1:0]   rd_map_r;
  logic                rd_map_vld_r;

  logic                issue;
  logic                map_we;
  logic                go;
  logic                exec_fire;

  logic [CNT_W-1:0]    cnt_cur;
  logic [NOTE_W-1:0]   map_cur;
  logic                mapped;
  logic [CNT_W:0]      cnt_inc;
  logic [CNT_W:0]      cnt_step;
  logic [CNT_W-1:0]    cnt_new;
  logic                emit;
  logic [STAT_W-1:0]   emit_status;

  logic                out_vld_r;
  logic [STAT_W-1:0]   status_r;
  logic [NOTE_W-1:0]   note_r;
  logic [VEL_W-1:0]    vel_r;

  assign cmd_addr = ADDR_W'(cmd.key);
  assign go       = !out_vld_r || pop;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (cmd_valid && cmd.op == OP_SAMPLE) begin
          state_nxt = BK_EXEC;
        end
      end
      BK_EXEC: begin
        if (go) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop   = 1'b0;
    issue     = 1'b0;
    map_we    = 1'b0;
    exec_fire = 1'b0;
    case (state_r)
      BK_IDLE: begin
        cmd_pop = cmd_valid;
        issue   = cmd_valid && (cmd.op == OP_SAMPLE);
        map_we  = cmd_valid && (cmd.op == OP_MAP);
      end
      BK_EXEC: begin
        exec_fire = go;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // entries never written read as reset values
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_vld_r <= '0;
      map_vld_r <= '0;
    end else begin
      if (exec_fire) begin
        cnt_vld_r[addr_r] <= 1'b1;
      end
      if (map_we) begin
        map_vld_r[cmd_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      cnt_mem[addr_r] <= cnt_new;
    end
    if (issue) begin
      rd_cnt_r     <= cnt_mem[cmd_addr];
      rd_cnt_vld_r <= cnt_vld_r[cmd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[cmd_addr] <= cmd.note;
    end
    if (issue) begin
      rd_map_r     <= map_mem[cmd_addr];
      rd_map_vld_r <= map_vld_r[cmd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      addr_r <= cmd_addr;
      lvl_r  <= cmd.level;
    end
  end

  // counter update
  assign cnt_cur  = rd_cnt_vld_r ? rd_cnt_r : '0;
  assign map_cur  = rd_map_vld_r ? rd_map_r : NOTE_UNMAPPED;
  assign mapped   = (map_cur != NOTE_UNMAPPED);
  assign cnt_inc  = {1'b0, cnt_cur} + (CNT_W+1)'(1);
  assign cnt_step = lvl_r ? cnt_inc : (CNT_W+1)'(1);

  always_comb begin
    cnt_new     = cnt_step[CNT_W-1:0];
    emit        = 1'b0;
    emit_status = STATUS_OFF;
    if (cnt_cur == '0) begin
      // released key: press only
      cnt_new     = lvl_r ? '0 : CNT_W'(1);
      emit        = !lvl_r && mapped;
      emit_status = STATUS_ON;
    end else if (cnt_step > {1'b0, cfg.timeout}) begin
      cnt_new = '0;
      emit    = mapped;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (exec_fire && emit) begin
      out_vld_r <= 1'b1;
    end else if (pop) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire && emit) begin
      status_r <= emit_status;
      note_r   <= map_cur + cfg.offset;
      vel_r    <= (emit_status == STATUS_ON) ? cfg.velocity : '0;
    end
  end

  assign empty       = !out_vld_r;
  assign status_byte = status_r;
  assign note_number = note_r;
  assign velocity    = vel_r;

endmodule

FILE: rtl/core/key_release_debounce_midi_core.sv
// Flow: items pass a 2-entry queue that absorbs bursts; a map write lands in the note map on
//   dequeue; a pin sample reads both memories, then updates its counter and loads any result.
// Throughput: a pin sample holds the back-end sequencer through read, update and write back,
//   and while a result is unread; otherwise map writes drain at one per cycle.
// Reset: synchronous, active low; counters read as released and all keys as unmapped at once,
//   no clearing pass; registers return to timeout 25, offset 47, velocity 127.
module key_release_debounce_midi_core
  import krd_pkg::*;
#(
  parameter int NUM_KEYS = NUM_KEYS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,

  // item input queue
  input  logic               push,
  output logic               full,
  input  logic               in_operation,
  input  logic [KEY_W-1:0]   in_key_index,
  input  logic               in_pin_level,
  input  logic [NOTE_W-1:0]  in_map_note,

  // result queue
  output logic               empty,
  input  logic               pop,
  output logic [STAT_W-1:0]  out_status_byte,
  output logic [NOTE_W-1:0]  out_note_number,
  output logic [VEL_W-1:0]   out_velocity,

  // register port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  krd_cfg_t   cfg;
  krd_cmd_t   cmd;
  logic       cmd_valid;
  logic       cmd_pop;

  logic [CNT_W-1:0]  cfg_timeout_r;
  logic [NOTE_W-1:0] cfg_offset_r;
  logic [VEL_W-1:0]  cfg_velocity_r;
  logic              cfg_wr;
  logic [1:0]        cfg_sel;

  // Register file. Word index in paddr[3:2]; the fourth slot reads zero and
  // ignores writes.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_sel = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_timeout_r  <= TIMEOUT_RST;
      cfg_offset_r   <= OFFSET_RST;
      cfg_velocity_r <= VELOCITY_RST;
    end else if (cfg_wr) begin
      case (cfg_sel)
        REG_TIMEOUT:  cfg_timeout_r  <= pwdata[CNT_W-1:0];
        REG_OFFSET:   cfg_offset_r   <= pwdata[NOTE_W-1:0];
        REG_VELOCITY: cfg_velocity_r <= pwdata[VEL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_TIMEOUT:  prdata = 32'(cfg_timeout_r);
      REG_OFFSET:   prdata = 32'(cfg_offset_r);
      REG_VELOCITY: prdata = 32'(cfg_velocity_r);
      default:      prdata = '0;
    endcase
  end

  assign cfg = '{timeout:  cfg_timeout_r,
                 offset:   cfg_offset_r,
                 velocity: cfg_velocity_r};

  // Front end: takes every item while not full, drops keys past the end, queues the rest.
  krd_front #(
    .NUM_KEYS (NUM_KEYS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .operation (in_operation),
    .key_index (in_key_index),
    .pin_level (in_pin_level),
    .map_note  (in_map_note),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  // Back end: owns the per-key counter and note map memories. A map write
  // is done on dequeue; a sample reads both memories, then updates the
  // counter and loads the result register if a note event comes out. It
  // holds in the update step while an earlier result is still unread.
  krd_back #(
    .NUM_KEYS (NUM_KEYS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_pop     (cmd_pop),
    .empty       (empty),
    .pop         (pop),
    .status_byte (out_status_byte),
    .note_number (out_note_number),
    .velocity    (out_velocity)
  );

endmodule

FILE: rtl/core/krd_checker.sv
module krd_checker
  import krd_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               full,
  input logic               empty,
  input logic               pop,
  input logic [STAT_W-1:0]  out_status_byte,
  input logic [NOTE_W-1:0]  out_note_number,
  input logic [VEL_W-1:0]   out_velocity
);

  // the result queue comes out of reset empty and the item queue not full
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (empty && !full))
    else $error("queues not empty after reset");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_status_byte == STATUS_ON || out_status_byte == STATUS_OFF))
    else $error("bad status byte");

  a_off_velocity: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_status_byte == STATUS_OFF) |-> (out_velocity == '0))
    else $error("note-off with nonzero velocity");

  a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_status_byte)
                          && $stable(out_note_number) && $stable(out_velocity)))
    else $error("waiting result changed");

endmodule

bind key_release_debounce_midi_core krd_checker u_krd_checker (.*);
